@@ rtl/core/itf_pkg.sv @@
package itf_pkg;

  localparam int DEF_MAX_FIELD  = 64;
  localparam int DEF_VALUE_BITS = 64;
  localparam int CFG_W          = 7;
  localparam int NDIG_W         = 7;
  localparam int NPH            = 9;

  localparam logic [1:0] RADIX_BIN = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_DEC = 2'd2;
  localparam logic [1:0] RADIX_HEX = 2'd3;

  localparam logic [2:0] REG_FIELD_WIDTH  = 3'd0;
  localparam logic [2:0] REG_PRECISION    = 3'd1;
  localparam logic [2:0] REG_PREC_ENABLE  = 3'd2;
  localparam logic [2:0] REG_FLAG_PLUS    = 3'd3;
  localparam logic [2:0] REG_FLAG_SPACE   = 3'd4;
  localparam logic [2:0] REG_FLAG_ALT     = 3'd5;
  localparam logic [2:0] REG_FLAG_ZERO    = 3'd6;
  localparam logic [2:0] REG_FLAG_LEFT    = 3'd7;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_X_LO  = 8'h78;

  typedef struct packed {
    logic [63:0] value;
    logic        twos_comp;
    logic [1:0]  radix_select;
    logic        upper_hex;
    logic        big_o_prefix;
  } in_item_t;

  typedef struct packed {
    logic [63:0] chars;
    logic [3:0]  byte_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] field_width;
    logic [CFG_W-1:0] precision;
    logic             precision_enable;
    logic             flag_plus;
    logic             flag_space;
    logic             flag_alternate;
    logic             flag_zero_fill;
    logic             flag_left_justify;
  } cfg_t;

  typedef struct packed {
    logic              negative;
    logic              is_zero;
    logic [1:0]        radix;
    logic              upper;
    logic              big_o;
    logic [NDIG_W-1:0] ndig;
  } dinfo_t;

  typedef enum logic [1:0] {CV_IDLE, CV_DEC, CV_NORM} conv_state_t;
  typedef enum logic [1:0] {PK_IDLE, PK_GEN, PK_OUT} pack_state_t;
  typedef enum logic [3:0] {
    PH_LPAD, PH_SIGN, PH_BIGO0, PH_BIGOO, PH_PFX0, PH_PFX1, PH_ZERO, PH_DIG, PH_RPAD
  } phase_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'b0, d};
    end else begin
      base = upper ? CH_A_UP : CH_A_LO;
      digit_char = base + {4'b0, d} - 8'd10;
    end
  endfunction

endpackage

@@ rtl/core/integer_to_text_formatter.sv @@
// Integer to text formatter.
// Input channel in_valid/in_ready/in_data carries one integer item with its
// signedness, radix, hex case and 0o request. Result channel out_valid/
// out_ready/out_data returns the text, up to eight ASCII chars per result with the
// first char in the low byte, byte_count and a last mark; empty text gives
// one result with byte_count 0. Formatting registers are to be written on the
// cfg_we/cfg_index/cfg_wdata port only while the block is idle (not enforced).
// One item at a time: in_ready is low from acceptance until the last result
// is taken. Digit conversion: decimal takes VALUE_BITS double-dabble shifts
// plus up to 19 leading-zero steps; other radices take up to VALUE_BITS-1
// leading-zero steps on the digit shift register. Text then leaves one char
// per cycle, pausing while each result is handed out, plus up to eight
// layout steps at the phase changes.
// A stalled receiver holds the current result; char generation waits with it.
// Synchronous reset returns both sequencers to idle and clears the formatting
// registers to 0 (no width, no precision, no flags).
module integer_to_text_formatter import itf_pkg::*; #(
  parameter int MAX_FIELD  = DEF_MAX_FIELD,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  cfg_t       cfg_r;
  dinfo_t     info;
  logic [3:0] top_digit;
  logic       conv_busy, conv_done, pack_busy, pop, start;
  logic [CFG_W-1:0] field_sat;

  always_comb begin
    field_sat = ({1'b0, cfg_wdata} > 8'(MAX_FIELD)) ? CFG_W'(MAX_FIELD) : cfg_wdata;
    in_ready  = !conv_busy && !pack_busy;
    start     = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIELD_WIDTH: cfg_r.field_width       <= field_sat;
        REG_PRECISION:   cfg_r.precision         <= field_sat;
        REG_PREC_ENABLE: cfg_r.precision_enable  <= cfg_wdata[0];
        REG_FLAG_PLUS:   cfg_r.flag_plus         <= cfg_wdata[0];
        REG_FLAG_SPACE:  cfg_r.flag_space        <= cfg_wdata[0];
        REG_FLAG_ALT:    cfg_r.flag_alternate    <= cfg_wdata[0];
        REG_FLAG_ZERO:   cfg_r.flag_zero_fill    <= cfg_wdata[0];
        REG_FLAG_LEFT:   cfg_r.flag_left_justify <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  itf_conv #(.VALUE_BITS(VALUE_BITS)) u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .item      (in_data),
    .pop       (pop),
    .info      (info),
    .top_digit (top_digit),
    .busy      (conv_busy),
    .done      (conv_done)
  );

  itf_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (conv_done),
    .info      (info),
    .top_digit (top_digit),
    .cfg       (cfg_r),
    .pop       (pop),
    .busy      (pack_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("item accepted while a result is pending");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready right after accept");
  a_full_words: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |-> (out_data.byte_count == 4'd8))
    else $error("short result before last");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.byte_count <= 4'd8)) else $error("byte count over 8");
`endif

endmodule

@@ rtl/core/itf_conv.sv @@
module itf_conv import itf_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  in_item_t   item,
  input  logic       pop,
  output dinfo_t     info,
  output logic [3:0] top_digit,
  output logic       busy,
  output logic       done
);

  localparam int NB   = VALUE_BITS;
  localparam int NOCT = (NB + 2) / 3;
  localparam int NHEX = (NB + 3) / 4;
  localparam int NDEC = ((NB * 1233) >> 12) + 1;
  localparam int CW   = $clog2(NB + 1);

  conv_state_t state_r, state_nxt;
  logic [NB-1:0][3:0] sr_r;
  logic [NB-1:0]      bin_r;
  logic [NDEC*4-1:0]  bcd_r;
  logic [CW-1:0]      cnt_r;
  logic [NDIG_W-1:0]  ndig_r;
  logic neg_r, zero_r, upper_r, bigo_r, done_r;
  logic [1:0] radix_r;

  logic [NB-1:0]      u, mag;
  logic               neg;
  logic [NOCT*3-1:0]  oext;
  logic [NHEX*4-1:0]  hext;
  logic [NB-1:0][3:0] sr_load, sr_dec, sr_shift;
  logic [NDIG_W-1:0]  ndig_load;
  logic [NDEC*4-1:0]  adj, bcd_nxt;
  logic [NB-1:0]      bin_nxt;
  logic               shrink;

  always_comb begin
    u    = item.value[NB-1:0];
    neg  = item.twos_comp & u[NB-1];
    mag  = neg ? (~u + {{(NB-1){1'b0}}, 1'b1}) : u;
    oext = (NOCT*3)'(mag);
    hext = (NHEX*4)'(mag);
    sr_load   = '0;
    ndig_load = NDIG_W'(NB);
    case (item.radix_select)
      RADIX_BIN: begin
        for (int k = 0; k < NB; k++) sr_load[k] = {3'b000, mag[k]};
      end
      RADIX_OCT: begin
        for (int k = 0; k < NOCT; k++) sr_load[NB-NOCT+k] = {1'b0, oext[3*k +: 3]};
        ndig_load = NDIG_W'(NOCT);
      end
      RADIX_HEX: begin
        for (int k = 0; k < NHEX; k++) sr_load[NB-NHEX+k] = hext[4*k +: 4];
        ndig_load = NDIG_W'(NHEX);
      end
      default: ndig_load = NDIG_W'(NDEC);
    endcase
  end

  // double dabble: add 3 to every BCD digit of 5 or more, then shift in a bit
  always_comb begin
    for (int k = 0; k < NDEC; k++) begin
      adj[4*k +: 4] = (bcd_r[4*k +: 4] >= 4'd5) ? bcd_r[4*k +: 4] + 4'd3 : bcd_r[4*k +: 4];
    end
    bcd_nxt = {adj[NDEC*4-2:0], bin_r[NB-1]};
    bin_nxt = {bin_r[NB-2:0], 1'b0};
    sr_dec  = '0;
    for (int k = 0; k < NDEC; k++) sr_dec[NB-NDEC+k] = bcd_nxt[4*k +: 4];
    sr_shift = {sr_r[NB-2:0], 4'h0};
    shrink   = (ndig_r > NDIG_W'(1)) && (sr_r[NB-1] == 4'h0);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CV_IDLE: if (start) state_nxt = (item.radix_select == RADIX_DEC) ? CV_DEC : CV_NORM;
      CV_DEC:  if (cnt_r == CW'(1)) state_nxt = CV_NORM;
      CV_NORM: if (!shrink) state_nxt = CV_IDLE;
      default: state_nxt = CV_IDLE;
    endcase
  end

  always_comb begin
    busy = (state_r != CV_IDLE) || done_r;
    done = done_r;
    top_digit = sr_r[NB-1];
    info = '{negative: neg_r, is_zero: zero_r, radix: radix_r, upper: upper_r,
             big_o: bigo_r, ndig: ndig_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == CV_NORM) && !shrink;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      CV_IDLE: begin
        if (start) begin
          neg_r   <= neg;
          zero_r  <= (mag == '0);
          radix_r <= item.radix_select;
          upper_r <= item.upper_hex;
          bigo_r  <= item.big_o_prefix;
          bin_r   <= mag;
          bcd_r   <= '0;
          cnt_r   <= CW'(NB);
          sr_r    <= sr_load;
          ndig_r  <= ndig_load;
        end else if (pop) begin
          sr_r <= sr_shift;
        end
      end
      CV_DEC: begin
        bcd_r <= bcd_nxt;
        bin_r <= bin_nxt;
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) sr_r <= sr_dec;
      end
      CV_NORM: begin
        if (shrink) begin
          sr_r   <= sr_shift;
          ndig_r <= ndig_r - NDIG_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/core/itf_pack.sv @@
module itf_pack import itf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  dinfo_t     info,
  input  logic [3:0] top_digit,
  input  cfg_t       cfg,
  output logic       pop,
  output logic       busy,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  pack_state_t state_r, state_nxt;
  phase_t      ph_r, ph_next;
  logic [7:0]  rem_r;
  logic [7:0]  len_r [NPH];
  logic [8:0]  tot_r;
  logic [63:0] word_r;
  logic [3:0]  cnt_r;
  logic        last_r;

  logic       shown, special, emit, word_done;
  logic [6:0] want;
  logic [7:0] ndig8, want8, zcnt, pfx, len_ld [NPH];
  logic [8:0] clen, fw9, pad, total;
  logic [7:0] ch;

  // text layout: pad, sign, 0o, radix prefix, zeros, digits, pad
  always_comb begin
    shown   = info.negative | cfg.flag_plus | cfg.flag_space;
    special = cfg.precision_enable && (cfg.precision == '0) && info.is_zero;
    if (cfg.precision_enable) want = cfg.precision;
    else if (cfg.flag_zero_fill && !cfg.flag_left_justify && cfg.field_width != '0)
      want = cfg.field_width - {6'b0, shown};
    else want = '0;
    ndig8 = 8'(info.ndig);
    want8 = 8'(want);
    zcnt  = (want8 > ndig8) ? want8 - ndig8 : 8'd0;
    case (info.radix)
      RADIX_BIN: pfx = 8'd2;
      RADIX_OCT: pfx = (zcnt == 8'd0 && !info.is_zero) ? 8'd1 : 8'd0;
      RADIX_HEX: pfx = 8'd2;
      default:   pfx = 8'd0;
    endcase
    if (!cfg.flag_alternate || special) pfx = 8'd0;
    len_ld[PH_SIGN]  = {7'b0, !special & shown};
    len_ld[PH_BIGO0] = {7'b0, !special & info.big_o};
    len_ld[PH_BIGOO] = {7'b0, !special & info.big_o};
    len_ld[PH_PFX0]  = {7'b0, pfx != 8'd0};
    len_ld[PH_PFX1]  = {7'b0, pfx == 8'd2};
    len_ld[PH_ZERO]  = special ? 8'd0 : zcnt;
    len_ld[PH_DIG]   = special ? 8'd0 : ndig8;
    clen = 9'(len_ld[PH_SIGN]) + 9'(len_ld[PH_BIGO0]) + 9'(len_ld[PH_BIGOO])
         + 9'(pfx) + 9'(len_ld[PH_ZERO]) + 9'(len_ld[PH_DIG]);
    fw9   = 9'(cfg.field_width);
    pad   = (fw9 > clen) ? fw9 - clen : 9'd0;
    total = clen + pad;
    len_ld[PH_LPAD] = cfg.flag_left_justify ? 8'd0 : pad[7:0];
    len_ld[PH_RPAD] = cfg.flag_left_justify ? pad[7:0] : 8'd0;
  end

  always_comb begin
    ph_next = phase_t'(ph_r + 4'd1);
    case (ph_r)
      PH_SIGN:  ch = info.negative ? CH_MINUS : (cfg.flag_plus ? CH_PLUS : CH_SPACE);
      PH_BIGO0: ch = CH_ZERO;
      PH_BIGOO: ch = CH_O;
      PH_PFX0:  ch = CH_ZERO;
      PH_PFX1:  ch = (info.radix == RADIX_BIN) ? CH_B : (info.upper ? CH_X_UP : CH_X_LO);
      PH_ZERO:  ch = CH_ZERO;
      PH_DIG:   ch = digit_char(top_digit, info.upper);
      default:  ch = CH_SPACE;
    endcase
  end

  always_comb begin
    busy      = (state_r != PK_IDLE);
    out_valid = (state_r == PK_OUT);
    emit      = (state_r == PK_GEN) && (rem_r != 8'd0);
    pop       = emit && (ph_r == PH_DIG);
    word_done = emit && ((cnt_r == 4'd7) || (tot_r == 9'd1));
    out_data  = '{chars: word_r, byte_count: cnt_r, last: last_r};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      PK_IDLE: if (start) state_nxt = (total == 9'd0) ? PK_OUT : PK_GEN;
      PK_GEN:  if (word_done) state_nxt = PK_OUT;
      PK_OUT:  if (out_ready) state_nxt = last_r ? PK_IDLE : PK_GEN;
      default: state_nxt = PK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= PK_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      PK_IDLE: begin
        if (start) begin
          for (int p = 0; p < NPH; p++) len_r[p] <= len_ld[p];
          ph_r   <= PH_LPAD;
          rem_r  <= len_ld[PH_LPAD];
          tot_r  <= total;
          word_r <= '0;
          cnt_r  <= '0;
          last_r <= (total == 9'd0);
        end
      end
      PK_GEN: begin
        if (emit) begin
          word_r[{cnt_r[2:0], 3'b000} +: 8] <= ch;
          cnt_r  <= cnt_r + 4'd1;
          tot_r  <= tot_r - 9'd1;
          rem_r  <= rem_r - 8'd1;
          last_r <= (tot_r == 9'd1);
        end else begin
          // empty phase step, no char this cycle
          ph_r  <= ph_next;
          rem_r <= (ph_r == PH_RPAD) ? 8'd0 : len_r[ph_next];
        end
      end
      PK_OUT: begin
        if (out_ready) begin
          word_r <= '0;
          cnt_r  <= '0;
        end
      end
      default: ;
    endcase
  end

endmodule
